// File: rtl/ldpq_pkg.sv
// ----------------------------------------------------------------------------
// ldpq_pkg - shared types and constants for the log delta pixel quantizer
// Pixel width, snap thresholds and the request struct passed to the
// quantizer datapath.
// ----------------------------------------------------------------------------
package ldpq_pkg;

    localparam int unsigned PIXEL_W    = 8;
    localparam int unsigned SNAP_STEPS = 7;    // powers of two 2 .. 128

    localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;
    localparam logic [PIXEL_W-1:0] SMALL_MAX = 8'd2;

    // Upper magnitude bound that still snaps to 2**k, index k = 1 .. 7.
    localparam logic [PIXEL_W-1:0] THR_NORM [1:SNAP_STEPS] = '{
        8'(2   + (2   * 7) / 12),
        8'(4   + (4   * 7) / 12),
        8'(8   + (8   * 7) / 12),
        8'(16  + (16  * 7) / 12),
        8'(32  + (32  * 7) / 12),
        8'(64  + (64  * 7) / 12),
        8'(128 + (128 * 7) / 12)
    };

    localparam logic [PIXEL_W-1:0] THR_WIDE [1:SNAP_STEPS] = '{
        8'(2   + (2 * 2)   / 3),
        8'(4   + (2 * 4)   / 3),
        8'(8   + (2 * 8)   / 3),
        8'(16  + (2 * 16)  / 3),
        8'(32  + (2 * 32)  / 3),
        8'(64  + (2 * 64)  / 3),
        8'(128 + (2 * 128) / 3)
    };

    typedef logic [PIXEL_W-1:0] t_pixel;

    // Request handed from the input stage to the quantizer datapath.
    typedef struct packed {
        t_pixel prev;       // previous value after any segment reload
        t_pixel pixel;
        logic   bypass;
        logic   wide;
    } t_quant_req;

    // Snap a magnitude to 0, 1, 2, a power of two up to 128, or 255.
    function automatic t_pixel snap_magnitude(input t_pixel mag, input logic wide);
        t_pixel res;
        t_pixel thr;
        res = PIXEL_MAX;
        // Walk down so the smallest matching power of two wins.
        for (int k = SNAP_STEPS; k >= 1; k--) begin
            thr = wide ? THR_WIDE[k] : THR_NORM[k];
            if (mag <= thr) begin
                res = t_pixel'(1 << k);
            end
        end
        if (mag <= SMALL_MAX) begin
            res = mag;
        end
        return res;
    endfunction

endpackage

// File: rtl/ldpq_stream_if.sv
// ----------------------------------------------------------------------------
// ldpq_in_if / ldpq_out_if - valid/ready channels of the quantizer
// Input carries the pixel request, output carries the quantized pixel.
// ----------------------------------------------------------------------------
interface ldpq_in_if;
    logic                 valid;
    logic                 ready;
    ldpq_pkg::t_pixel     pixel;
    ldpq_pkg::t_pixel     reference;
    logic                 segment_start;
    logic                 bypass;

    modport source (output valid, output pixel, output reference,
                    output segment_start, output bypass, input ready);
    modport sink   (input valid, input pixel, input reference,
                    input segment_start, input bypass, output ready);
endinterface

interface ldpq_out_if;
    logic                 valid;
    logic                 ready;
    ldpq_pkg::t_pixel     result_pixel;

    modport source (output valid, output result_pixel, input ready);
    modport sink   (input valid, input result_pixel, output ready);
endinterface

// File: rtl/ldpq_quant.sv
// ----------------------------------------------------------------------------
// ldpq_quant - quantizer datapath
// Snaps the delta to the previous value, applies it and saturates at either end; bypass passes the pixel.
// ----------------------------------------------------------------------------
module ldpq_quant (
    input  ldpq_pkg::t_quant_req i_req,
    output ldpq_pkg::t_pixel     o_result
);

    ldpq_pkg::t_pixel                 w_mag;
    ldpq_pkg::t_pixel                 w_step;
    logic                             w_up;
    logic [ldpq_pkg::PIXEL_W:0]       w_sum;

    assign w_up   = (i_req.pixel >= i_req.prev);
    assign w_mag  = w_up ? (i_req.pixel - i_req.prev) : (i_req.prev - i_req.pixel);
    assign w_step = ldpq_pkg::snap_magnitude(w_mag, i_req.wide);
    assign w_sum  = {1'b0, i_req.prev} + {1'b0, w_step};

    always_comb begin
        if (i_req.bypass) begin
            o_result = i_req.pixel;
        end else if (w_up) begin
            // saturate at full scale
            o_result = w_sum[ldpq_pkg::PIXEL_W] ? ldpq_pkg::PIXEL_MAX
                                                : w_sum[ldpq_pkg::PIXEL_W-1:0];
        end else begin
            // clamp at zero
            o_result = (w_step > i_req.prev) ? '0 : (i_req.prev - w_step);
        end
    end

endmodule

// File: rtl/log_delta_pixel_quantizer.sv
// ----------------------------------------------------------------------------
// log_delta_pixel_quantizer - DPCM pixel quantizer with logarithmic steps
// Streams 8-bit pixels along a line and emits each one as the last emitted
// value plus or minus a snapped step, saturated, or the pixel under bypass.
//
// Usage:
//   i_in   : pixel requests (pixel, reference, segment_start, bypass) under
//            valid/ready; a request is taken when valid and ready are high.
//   o_out  : one result_pixel per request, in order, under valid/ready.
//   i_cfg_we / i_cfg_wdata : write wide_threshold; change it only when idle.
//   Path: a taken request is held in the input register, then quantized
//   into the result register. Throughput: one request per cycle while the
//   receiver takes results, set by the single quantize step between the
//   two registers, with the kept value updated at the same edge as the result.
//   Receiver stall: the result holds, the input register holds one more
//   request, then ready drops until the result is taken.
//   Reset (i_rst_n low, synchronous): both stages empty, previous value 0,
//   wide_threshold 0.
// ----------------------------------------------------------------------------
module log_delta_pixel_quantizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    ldpq_in_if.sink     i_in,
    ldpq_out_if.source  o_out
);

    // input stage
    logic                  r_in_valid;
    ldpq_pkg::t_pixel      r_pixel;
    ldpq_pkg::t_pixel      r_reference;
    logic                  r_segment_start;
    logic                  r_bypass;

    // result stage and kept state
    logic                  r_out_valid;
    ldpq_pkg::t_pixel      r_result;
    ldpq_pkg::t_pixel      r_prev;
    logic                  r_wide;

    logic                  w_advance;
    logic                  w_take;
    ldpq_pkg::t_quant_req  w_req;
    ldpq_pkg::t_pixel      w_result;

    // Advance the held request when the result slot is free or being taken.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_take     = i_in.valid && i_in.ready;

    // Segment start reloads the previous value before quantizing.
    assign w_req.prev   = r_segment_start ? r_reference : r_prev;
    assign w_req.pixel  = r_pixel;
    assign w_req.bypass = r_bypass;
    assign w_req.wide   = r_wide;

    ldpq_quant u_quant (
        .i_req    (w_req),
        .o_result (w_result)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_wide      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wide <= i_cfg_wdata;
            end
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_prev      <= w_result;   // keep what is emitted
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pixel         <= i_in.pixel;
            r_reference     <= i_in.reference;
            r_segment_start <= i_in.segment_start;
            r_bypass        <= i_in.bypass;
        end
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_pixel = r_result;

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the log delta pixel quantizer
// Runs a short table of hand-picked requests (extremes, bypass, segment
// reload, both flags, saturation at either end), then random request
// streams under both threshold modes. Each result is checked against a predictor
// or a pinned row's typed-in value; both channels idle at random but for the last run.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned WATCHDOG_LIMIT = 400;
    localparam int unsigned DIRECTED_ROWS  = 18;

    // One row of the directed table; pinned rows carry a typed-in result.
    typedef struct packed {
        ldpq_pkg::t_pixel pixel;
        ldpq_pkg::t_pixel reference;
        logic             segment_start;
        logic             bypass;
        logic             pinned;
        ldpq_pkg::t_pixel pinned_pixel;
    } t_line_row;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ldpq_in_if  in_if ();
    ldpq_out_if out_if ();

    log_delta_pixel_quantizer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Predictor state: last emitted value and threshold mode.
    ldpq_pkg::t_pixel kept_pixel;
    logic             wide_mode;
    ldpq_pkg::t_pixel expected_pixels [$];
    logic             row_pinned;
    ldpq_pkg::t_pixel row_value;
    logic             quiet_run;
    int unsigned      idle_cycles;
    int unsigned      mismatch_count;

    // Starting from a kept value of 0 with narrow thresholds.
    t_line_row directed_rows [DIRECTED_ROWS] = '{
        '{8'd0,   8'd0,   1'b0, 1'b0, 1'b1, 8'd0},    // no change
        '{8'd255, 8'd0,   1'b0, 1'b0, 1'b1, 8'd255},  // above every threshold
        '{8'd0,   8'd0,   1'b0, 1'b0, 1'b1, 8'd0},    // full swing down
        '{8'd1,   8'd0,   1'b0, 1'b0, 1'b1, 8'd1},
        '{8'd3,   8'd0,   1'b0, 1'b0, 1'b1, 8'd3},    // magnitude 2 kept as is
        '{8'd6,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
        '{8'd200, 8'd0,   1'b0, 1'b1, 1'b1, 8'd200},  // bypass
        '{8'd77,  8'd50,  1'b1, 1'b1, 1'b1, 8'd77},   // both flags: bypass wins
        '{8'd255, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
        '{8'd255, 8'd200, 1'b1, 1'b0, 1'b1, 8'd255},  // saturate high
        '{8'd0,   8'd55,  1'b1, 1'b0, 1'b1, 8'd0},    // saturate low
        '{8'd13,  8'd0,   1'b1, 1'b0, 1'b0, 8'd0},
        '{8'd0,   8'd255, 1'b1, 1'b0, 1'b1, 8'd0},
        '{8'd255, 8'd0,   1'b1, 1'b0, 1'b1, 8'd255},
        '{8'd128, 8'd128, 1'b1, 1'b0, 1'b1, 8'd128},
        '{8'd126, 8'd128, 1'b1, 1'b0, 1'b1, 8'd126},
        '{8'd170, 8'd255, 1'b1, 1'b1, 1'b1, 8'd170},
        '{8'd85,  8'd170, 1'b0, 1'b0, 1'b0, 8'd0}
    };

    initial clk = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Snap a magnitude: small ones stay, else the first power of two whose
    // threshold covers it, else full scale.
    function automatic logic [9:0] snapped_step(input ldpq_pkg::t_pixel mag,
                                                input logic wide);
        logic [11:0] pow_step;
        logic [11:0] narrow_lim;
        logic [11:0] wide_lim;
        if (mag <= 8'd2) begin
            return {2'b00, mag};
        end
        for (int s = 1; s <= 7; s++) begin
            pow_step   = 12'd1 << s;
            narrow_lim = pow_step + (pow_step * 12'd7) / 12'd12;
            wide_lim   = pow_step + (12'd2 * pow_step) / 12'd3;
            if (mag <= narrow_lim || (wide && mag <= wide_lim)) begin
                return pow_step[9:0];
            end
        end
        return 10'd255;
    endfunction

    // Work out the next result and advance the kept value.
    function automatic ldpq_pkg::t_pixel quantize_pixel(input ldpq_pkg::t_pixel pix,
                                                        input ldpq_pkg::t_pixel refv,
                                                        input logic seg, input logic byp);
        logic [9:0]       step;
        logic [9:0]       sum;
        ldpq_pkg::t_pixel res;
        if (seg) begin
            kept_pixel = refv;
        end
        if (byp) begin
            res = pix;
        end else if (pix >= kept_pixel) begin
            sum = {2'b00, kept_pixel} + snapped_step(pix - kept_pixel, wide_mode);
            res = (sum > 10'd255) ? ldpq_pkg::PIXEL_MAX : sum[7:0];
        end else begin
            step = snapped_step(kept_pixel - pix, wide_mode);
            res  = (step > {2'b00, kept_pixel}) ? 8'd0
                                                 : ldpq_pkg::t_pixel'({2'b00, kept_pixel} - step);
        end
        kept_pixel = res;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input ldpq_pkg::t_pixel got,
                                   input ldpq_pkg::t_pixel want);
        mismatch_count++;
        $display("[%0t] mismatch: %s, got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Record requests and check results at the same edge, in one process.
    always @(posedge clk) begin : monitor
        ldpq_pkg::t_pixel want;
        ldpq_pkg::t_pixel got;
        if (!rst_n) begin
            kept_pixel  = '0;
            wide_mode   = 1'b0;
            idle_cycles = 0;
        end else begin
            if (cfg_we) begin
                wide_mode = cfg_wdata;
            end
            if (in_if.valid && in_if.ready) begin
                want = quantize_pixel(in_if.pixel, in_if.reference,
                                      in_if.segment_start, in_if.bypass);
                expected_pixels.push_back(row_pinned ? row_value : want);
            end
            if (out_if.valid && out_if.ready) begin
                got = out_if.result_pixel;
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result with nothing expected", got, got);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        report_mismatch("result_pixel", got, want);
                    end
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    // Stall the result side in bursts; hold ready high once the run goes quiet.
    initial begin
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!quiet_run && $urandom_range(0, 9) == 0) begin
                out_if.ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_if.ready = 1'b1;
            end else if (!quiet_run && $urandom_range(0, 19) == 0) begin
                out_if.ready = 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    initial begin
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Present one request at the falling edge and hold it until taken.
    task automatic send_request(input ldpq_pkg::t_pixel pix, input ldpq_pkg::t_pixel refv,
                                input logic seg, input logic byp, input logic pin,
                                input ldpq_pkg::t_pixel pin_value);
        if (!quiet_run && $urandom_range(0, 4) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_if.valid         = 1'b1;
        in_if.pixel         = pix;
        in_if.reference     = refv;
        in_if.segment_start = seg;
        in_if.bypass        = byp;
        row_pinned          = pin;
        row_value           = pin_value;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic write_wide(input logic value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic wait_for_results();
        in_if.valid = 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random requests; most reload a reference, and some aim the delta near a
    // snap threshold so both modes are told apart.
    task automatic run_phase(input logic wide, input int count);
        ldpq_pkg::t_pixel pix;
        ldpq_pkg::t_pixel refv;
        logic             seg;
        logic             byp;
        int unsigned      kind;
        int unsigned      pow_step;
        int unsigned      lim;
        int unsigned      mag;
        write_wide(wide);
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            refv = ldpq_pkg::t_pixel'($urandom);
            pix  = ldpq_pkg::t_pixel'($urandom);
            seg  = 1'b0;
            byp  = 1'b0;
            if (kind <= 3) begin
                seg      = 1'b1;
                pow_step = 1 << $urandom_range(1, 7);
                lim      = $urandom_range(0, 1) ? pow_step + (pow_step * 7) / 12
                                                : pow_step + (2 * pow_step) / 3;
                mag      = (kind == 3) ? $urandom_range(0, 3) : lim + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1) == 1 && refv + mag <= 255) begin
                    pix = ldpq_pkg::t_pixel'(refv + mag);
                end else if (refv >= mag) begin
                    pix = ldpq_pkg::t_pixel'(refv - mag);
                end
            end else if (kind == 8) begin
                byp = 1'b1;
                seg = 1'($urandom_range(0, 1));
            end else if (kind == 9) begin
                seg = 1'b1;
            end
            send_request(pix, refv, seg, byp, 1'b0, '0);
        end
        wait_for_results();
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = 1'b0;
        in_if.valid         = 1'b0;
        in_if.pixel         = '0;
        in_if.reference     = '0;
        in_if.segment_start = 1'b0;
        in_if.bypass        = 1'b0;
        row_pinned          = 1'b0;
        row_value           = '0;
        quiet_run           = 1'b0;
        idle_cycles         = 0;
        mismatch_count      = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        write_wide(1'b0);
        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].pixel, directed_rows[r].reference,
                         directed_rows[r].segment_start, directed_rows[r].bypass,
                         directed_rows[r].pinned, directed_rows[r].pinned_pixel);
        end
        wait_for_results();

        run_phase(1'b1, 500);
        run_phase(1'b0, 450);
        run_phase(1'b1, 450);
        // Last stretch runs at full rate on both sides.
        quiet_run = 1'b1;
        run_phase(1'b0, 300);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/ldpq_pkg.sv
rtl/ldpq_stream_if.sv
rtl/ldpq_quant.sv
rtl/log_delta_pixel_quantizer.sv
test/tb_top.sv
